// ----- src/assert_macros.svh -----
// assertion macros for the eigenvalue pipeline
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define S2E_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define S2E_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define S2E_ASSERT(lbl, clk, rstn, prop)
`define S2E_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- src/s2e_pkg.sv -----
`timescale 1ns / 1ps
package s2e_pkg;

    localparam int IN_WIDTH  = 32;
    localparam int OUT_WIDTH = 40;
    localparam int MAG_W     = IN_WIDTH + 1;
    localparam int RAD_W     = 2 * IN_WIDTH + 2;
    localparam int ROOT_W    = IN_WIDTH + 1;
    localparam int SREM_W    = ROOT_W + 3;
    localparam int DET_W     = 2 * IN_WIDTH;
    localparam int DREM_W    = ROOT_W + 1;
    localparam int CMP_W     = DET_W + OUT_WIDTH;

    typedef struct packed {
        logic signed [MAG_W:0] sm;
        logic [RAD_W-1:0]      rad;
        logic [SREM_W-1:0]     srem;
        logic [ROOT_W-1:0]     root;
        logic                  dneg;
        logic [DET_W-1:0]      num;
        logic                  smz;
        logic                  r1neg;
        logic [ROOT_W-1:0]     r1mag;
        logic [DREM_W-1:0]     drem;
        logic [DET_W-1:0]      quo;
    } item_t;

    function automatic logic [OUT_WIDTH-1:0] sat_out(input logic neg,
                                                     input logic [DET_W-1:0] mag);
        logic [CMP_W-1:0] lim;
        logic [CMP_W-1:0] m;
        logic [CMP_W-1:0] v;
        lim = CMP_W'(1) << (OUT_WIDTH - 1);
        m   = CMP_W'(mag);
        if (neg)
        begin
            v = (m > lim) ? lim : m;
            v = ~v + CMP_W'(1);
        end
        else
        begin
            v = (m > lim - CMP_W'(1)) ? lim - CMP_W'(1) : m;
        end
        return v[OUT_WIDTH-1:0];
    endfunction

endpackage

// ----- src/s2e_sqrt_cell.sv -----
`timescale 1ns / 1ps
module s2e_sqrt_cell
    import s2e_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output item_t out_item
);

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;
    logic [SREM_W-1:0] cur;
    logic [SREM_W-1:0] trial;

    always_comb
    begin
        item_next     = in_item;
        cur           = {in_item.srem[SREM_W-3:0], in_item.rad[RAD_W-1:RAD_W-2]};
        trial         = SREM_W'({in_item.root, 2'b01});
        item_next.rad = {in_item.rad[RAD_W-3:0], 2'b00};
        if (cur >= trial)
        begin
            item_next.srem = cur - trial;
            item_next.root = {in_item.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            item_next.srem = cur;
            item_next.root = {in_item.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ----- src/s2e_div_cell.sv -----
`timescale 1ns / 1ps
module s2e_div_cell
    import s2e_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output item_t out_item
);

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;
    logic [DREM_W-1:0] cur;
    logic [DREM_W-1:0] dvs;

    always_comb
    begin
        item_next     = in_item;
        cur           = {in_item.drem[DREM_W-2:0], in_item.num[DET_W-1]};
        dvs           = DREM_W'(in_item.r1mag);
        item_next.num = {in_item.num[DET_W-2:0], 1'b0};
        if (cur >= dvs)
        begin
            item_next.drem = cur - dvs;
            item_next.quo  = {in_item.quo[DET_W-2:0], 1'b1};
        end
        else
        begin
            item_next.drem = cur;
            item_next.quo  = {in_item.quo[DET_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ----- src/sym2x2_eigenvalues.sv -----
// Eigenvalues of the symmetric 2x2 matrix [[a,b],[b,c]], entries signed Q15.16,
// results signed Q23.16.
// Input channel: entry_a, entry_b, entry_c are taken at a rising edge with
// start high and busy low. busy is always low, so a new matrix may be
// issued in every cycle.
// Output channel: done is high for one cycle with eig_large (eigenvalue of
// larger magnitude) and eig_small on the result ports. The receiver cannot
// stall; each beat must be taken in the cycle it appears.
// Throughput: one matrix per cycle. From the accepting edge an item passes three
// stages of sums and products, a chain of IN_WIDTH + 1 square root cells (two
// radicand bits each), the register of the large eigenvalue magnitude, a chain of
// 2 * IN_WIDTH divider cells (one quotient bit each) and the output register.
// Reset clears all valid flags; items in flight are dropped and no result
// appears until a new matrix is accepted.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sym2x2_eigenvalues
    import s2e_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [IN_WIDTH-1:0]  entry_a,
    input  logic signed [IN_WIDTH-1:0]  entry_b,
    input  logic signed [IN_WIDTH-1:0]  entry_c,
    output logic                        done,
    output logic signed [OUT_WIDTH-1:0] eig_large,
    output logic signed [OUT_WIDTH-1:0] eig_small
);

    logic accept;

    logic                  s1_v_reg;
    logic signed [MAG_W:0] s1_sm_reg;
    logic [MAG_W-1:0]      s1_dfm_reg;
    logic [MAG_W-1:0]      s1_tbm_reg;
    logic [IN_WIDTH-1:0]   s1_am_reg;
    logic [IN_WIDTH-1:0]   s1_bm_reg;
    logic [IN_WIDTH-1:0]   s1_cm_reg;
    logic                  s1_acneg_reg;
    logic signed [MAG_W:0] s1_sm_next;
    logic signed [MAG_W:0] s1_df_next;
    logic signed [MAG_W:0] s1_tb_next;
    logic [MAG_W:0]        s1_dfm_next;
    logic [MAG_W:0]        s1_tbm_next;

    logic                  s2_v_reg;
    logic signed [MAG_W:0] s2_sm_reg;
    logic [RAD_W-1:0]      s2_dd_reg;
    logic [RAD_W-1:0]      s2_tt_reg;
    logic [DET_W-1:0]      s2_ac_reg;
    logic [DET_W-1:0]      s2_bb_reg;
    logic                  s2_acneg_reg;

    logic                  s3_v_reg;
    item_t                 s3_item_reg;
    item_t                 s3_item_next;
    logic signed [DET_W:0] det;
    logic signed [DET_W:0] acs;
    logic [DET_W:0]        detm;

    logic  sq_v [0:ROOT_W];
    item_t sq_item [0:ROOT_W];

    logic            r1_v_reg;
    item_t           r1_item_reg;
    item_t           r1_item_next;
    logic [MAG_W:0]  smm;
    logic [ROOT_W:0] r1sum;

    logic  dv_v [0:DET_W];
    item_t dv_item [0:DET_W];

    logic                  out_v_reg;
    logic [OUT_WIDTH-1:0]  large_reg;
    logic [OUT_WIDTH-1:0]  small_reg;
    logic [OUT_WIDTH-1:0]  large_next;
    logic [OUT_WIDTH-1:0]  small_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // stage 1: sums, differences and magnitudes
    always_comb
    begin
        s1_sm_next  = $signed({entry_a[IN_WIDTH-1], entry_a[IN_WIDTH-1], entry_a})
                    + $signed({entry_c[IN_WIDTH-1], entry_c[IN_WIDTH-1], entry_c});
        s1_df_next  = $signed({entry_a[IN_WIDTH-1], entry_a[IN_WIDTH-1], entry_a})
                    - $signed({entry_c[IN_WIDTH-1], entry_c[IN_WIDTH-1], entry_c});
        s1_tb_next  = $signed({entry_b[IN_WIDTH-1], entry_b, 1'b0});
        s1_dfm_next = s1_df_next[MAG_W] ? (MAG_W+1)'(-s1_df_next) : s1_df_next;
        s1_tbm_next = s1_tb_next[MAG_W] ? (MAG_W+1)'(-s1_tb_next) : s1_tb_next;
    end

    always_ff @(posedge clk)
    begin
        s1_sm_reg    <= s1_sm_next;
        s1_dfm_reg   <= s1_dfm_next[MAG_W-1:0];
        s1_tbm_reg   <= s1_tbm_next[MAG_W-1:0];
        s1_am_reg    <= entry_a[IN_WIDTH-1] ? IN_WIDTH'(-entry_a) : entry_a;
        s1_bm_reg    <= entry_b[IN_WIDTH-1] ? IN_WIDTH'(-entry_b) : entry_b;
        s1_cm_reg    <= entry_c[IN_WIDTH-1] ? IN_WIDTH'(-entry_c) : entry_c;
        s1_acneg_reg <= entry_a[IN_WIDTH-1] ^ entry_c[IN_WIDTH-1];
    end

    // stage 2: products
    always_ff @(posedge clk)
    begin
        s2_sm_reg    <= s1_sm_reg;
        s2_dd_reg    <= RAD_W'(s1_dfm_reg) * RAD_W'(s1_dfm_reg);
        s2_tt_reg    <= RAD_W'(s1_tbm_reg) * RAD_W'(s1_tbm_reg);
        s2_ac_reg    <= DET_W'(s1_am_reg) * DET_W'(s1_cm_reg);
        s2_bb_reg    <= DET_W'(s1_bm_reg) * DET_W'(s1_bm_reg);
        s2_acneg_reg <= s1_acneg_reg;
    end

    // stage 3: sum of squares and determinant
    always_comb
    begin
        acs  = s2_acneg_reg ? -$signed({1'b0, s2_ac_reg}) : $signed({1'b0, s2_ac_reg});
        det  = acs - $signed({1'b0, s2_bb_reg});
        detm = det[DET_W] ? (DET_W+1)'(-det) : det;
        s3_item_next      = '0;
        s3_item_next.sm   = s2_sm_reg;
        s3_item_next.rad  = s2_dd_reg + s2_tt_reg;
        s3_item_next.dneg = det[DET_W];
        s3_item_next.num  = detm[DET_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        s3_item_reg <= s3_item_next;
    end

    assign sq_v[0]    = s3_v_reg;
    assign sq_item[0] = s3_item_reg;

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sqrt
        s2e_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_v[i]),
            .in_item   (sq_item[i]),
            .out_valid (sq_v[i+1]),
            .out_item  (sq_item[i+1])
        );
    end

    // large eigenvalue magnitude from the trace and the root
    always_comb
    begin
        r1_item_next      = sq_item[ROOT_W];
        smm               = sq_item[ROOT_W].sm[MAG_W] ? (MAG_W+1)'(-sq_item[ROOT_W].sm)
                                                      : sq_item[ROOT_W].sm;
        r1_item_next.smz  = (sq_item[ROOT_W].sm == '0);
        r1_item_next.drem = '0;
        r1_item_next.quo  = '0;
        if (sq_item[ROOT_W].sm == '0)
        begin
            r1sum              = (ROOT_W+1)'(sq_item[ROOT_W].root);
            r1_item_next.r1neg = 1'b0;
        end
        else if (!sq_item[ROOT_W].sm[MAG_W])
        begin
            r1sum              = (ROOT_W+1)'(smm) + (ROOT_W+1)'(sq_item[ROOT_W].root);
            r1_item_next.r1neg = 1'b0;
        end
        else
        begin
            r1sum              = (ROOT_W+1)'(smm) + (ROOT_W+1)'(sq_item[ROOT_W].root)
                               + (ROOT_W+1)'(1);
            r1_item_next.r1neg = 1'b1;
        end
        r1_item_next.r1mag = r1sum[ROOT_W:1];
    end

    always_ff @(posedge clk)
    begin
        r1_item_reg <= r1_item_next;
    end

    assign dv_v[0]    = r1_v_reg;
    assign dv_item[0] = r1_item_reg;

    for (genvar j = 0; j < DET_W; j++)
    begin : g_div
        s2e_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_v[j]),
            .in_item   (dv_item[j]),
            .out_valid (dv_v[j+1]),
            .out_item  (dv_item[j+1])
        );
    end

    // output encoding with saturation
    always_comb
    begin
        large_next = sat_out(dv_item[DET_W].r1neg && (dv_item[DET_W].r1mag != '0),
                             DET_W'(dv_item[DET_W].r1mag));
        if (dv_item[DET_W].smz)
            small_next = sat_out(dv_item[DET_W].r1mag != '0, DET_W'(dv_item[DET_W].r1mag));
        else if (dv_item[DET_W].r1mag == '0)
            small_next = '0;
        else
            small_next = sat_out((dv_item[DET_W].dneg != dv_item[DET_W].r1neg)
                                 && (dv_item[DET_W].quo != '0), dv_item[DET_W].quo);
    end

    always_ff @(posedge clk)
    begin
        large_reg <= large_next;
        small_reg <= small_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            r1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg  <= accept;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            r1_v_reg  <= sq_v[ROOT_W];
            out_v_reg <= dv_v[DET_W];
        end
    end

    assign done      = out_v_reg;
    assign eig_large = $signed(large_reg);
    assign eig_small = $signed(small_reg);

    `S2E_ASSERT_IMP(a_root_rem, clk, rst_n, sq_v[ROOT_W],
        sq_item[ROOT_W].srem <= SREM_W'({sq_item[ROOT_W].root, 1'b0}))
    `S2E_ASSERT_IMP(a_zero_large, clk, rst_n, done && (eig_large == '0), eig_small == '0)
    `S2E_ASSERT_IMP(a_div_latency, clk, rst_n, done, $past(r1_v_reg, DET_W + 1))

endmodule
